@@ hdl/dsst_pkg.sv @@
`timescale 1ns / 1ps
// dsst_pkg: shared types and constants for the dive safety stop tracker
// no dependencies; imported by every module of the block

package dsst_pkg;

  // stop phase codes
  typedef enum logic [1:0] {
    PH_NOT_STARTED = 2'd0,
    PH_IN_PROGRESS = 2'd1,
    PH_VIOLATED    = 2'd2,
    PH_DONE        = 2'd3
  } phase_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TRIGGER_DEPTH = 3'd0,
    CFG_WINDOW_SHALLOW = 3'd1,
    CFG_WINDOW_DEEP    = 3'd2,
    CFG_REARM_DEPTH    = 3'd3,
    CFG_STOP_TARGET    = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned DepthW    = 16;
  localparam int unsigned SecsW     = 16;
  localparam int unsigned TargetW   = 12;
  localparam int unsigned TimeFldW  = 6;

  // register reset values
  localparam logic [DepthW-1:0]  TRIGGER_RST = 16'd1000;
  localparam logic [DepthW-1:0]  SHALLOW_RST = 16'd300;
  localparam logic [DepthW-1:0]  DEEP_RST    = 16'd600;
  localparam logic [DepthW-1:0]  REARM_RST   = 16'd1000;
  localparam logic [TargetW-1:0] TARGET_RST  = 12'd180;

  // displayed countdown caps at 60:00
  localparam logic [TargetW-1:0] SHOW_LIMIT_S = 12'd3600;

  // rem / 60 as (rem * 2185) >> 17, exact for rem up to 3600
  localparam logic [TargetW-1:0] RECIP_60     = 12'd2185;
  localparam int unsigned        RECIP_SHIFT  = 17;
  localparam logic [TargetW-1:0] SECS_PER_MIN = 12'd60;

  typedef struct packed {
    logic [DepthW-1:0]  trigger_depth_cm;
    logic [DepthW-1:0]  window_shallow_cm;
    logic [DepthW-1:0]  window_deep_cm;
    logic [DepthW-1:0]  rearm_depth_cm;
    logic [TargetW-1:0] stop_target_s;
  } cfg_t;

  typedef struct packed {
    logic [DepthW-1:0] depth_cm;
    logic [SecsW-1:0]  interval_s;
    logic              new_dive;
    logic              deco_active;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]          stop_phase;
    logic                stop_shown;
    logic [TimeFldW-1:0] remaining_min;
    logic [TimeFldW-1:0] remaining_sec;
    logic [DepthW-1:0]   max_depth_out;
  } out_beat_t;

  // status of one sample after the stop machine has run
  typedef struct packed {
    phase_e             phase;
    logic               shown;
    logic [TargetW-1:0] rem_s;
    logic [DepthW-1:0]  max_depth;
  } stop_status_t;

endpackage

@@ hdl/dsst_stop_fsm.sv @@
`timescale 1ns / 1ps
// dsst_stop_fsm: max depth tracking and the four-phase safety stop machine
// depends on dsst_pkg

module dsst_stop_fsm import dsst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  in_beat_t     beat_i,
  input  cfg_t         cfg_i,
  output stop_status_t status_o
);

  phase_e            phase_q, phase_d;
  logic [SecsW-1:0]  secs_q, secs_d;
  logic [DepthW-1:0] max_q, max_d;
  logic              shown_q, shown_d;

  // next state
  always_comb begin
    phase_e            phase_b;
    logic [SecsW-1:0]  secs_b;
    logic [SecsW-1:0]  secs_t;
    logic [DepthW-1:0] max_b;
    logic              shown_b;
    logic              in_win;
    logic              eval;
    logic [SecsW:0]    sum;
    logic [SecsW-1:0]  sum_sat;

    // new dive clears everything before the sample is applied
    phase_b = beat_i.new_dive ? PH_NOT_STARTED : phase_q;
    secs_b  = beat_i.new_dive ? '0 : secs_q;
    max_b   = beat_i.new_dive ? '0 : max_q;
    shown_b = beat_i.new_dive ? 1'b0 : shown_q;

    max_d   = (max_b <= beat_i.depth_cm) ? beat_i.depth_cm : max_b;
    eval    = !beat_i.deco_active && (max_d > cfg_i.trigger_depth_cm);
    in_win  = (beat_i.depth_cm > cfg_i.window_shallow_cm) &&
              (beat_i.depth_cm < cfg_i.window_deep_cm);

    phase_d = phase_b;
    secs_d  = secs_b;
    shown_d = shown_b;
    secs_t  = (phase_b == PH_NOT_STARTED) ? '0 : secs_b;
    sum     = {1'b0, secs_t} + {1'b0, beat_i.interval_s};
    sum_sat = sum[SecsW] ? {SecsW{1'b1}} : sum[SecsW-1:0];

    if (eval) begin
      if (in_win) begin
        if (phase_b != PH_DONE) begin
          secs_d = sum_sat;
          if (sum_sat >= {{(SecsW-TargetW){1'b0}}, cfg_i.stop_target_s}) begin
            phase_d = PH_DONE;
            shown_d = 1'b0;
          end else begin
            phase_d = PH_IN_PROGRESS;
            shown_d = 1'b1;
          end
        end
      end else if (beat_i.depth_cm > cfg_i.rearm_depth_cm) begin
        if (phase_b != PH_NOT_STARTED) begin
          phase_d = PH_NOT_STARTED;
          shown_d = 1'b0;
          secs_d  = '0;
        end
      end else if (phase_b == PH_IN_PROGRESS) begin
        phase_d = PH_VIOLATED;
        shown_d = 1'b0;
      end
    end
  end

  // outputs: remaining time only while in progress
  always_comb begin
    logic [TargetW-1:0] rem;
    rem = '0;
    if (phase_d == PH_IN_PROGRESS &&
        secs_d <= {{(SecsW-TargetW){1'b0}}, cfg_i.stop_target_s}) begin
      rem = cfg_i.stop_target_s - secs_d[TargetW-1:0];
    end
    status_o.phase     = phase_d;
    status_o.shown     = shown_d;
    status_o.rem_s     = (rem > SHOW_LIMIT_S) ? SHOW_LIMIT_S : rem;
    status_o.max_depth = max_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NOT_STARTED;
      secs_q  <= '0;
      max_q   <= '0;
      shown_q <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      secs_q  <= secs_d;
      max_q   <= max_d;
      shown_q <= shown_d;
    end
  end

endmodule

@@ hdl/dsst_rem_split.sv @@
`timescale 1ns / 1ps
// dsst_rem_split: splits remaining seconds (up to 3600) into minutes and seconds
// depends on dsst_pkg; divide by 60 through a reciprocal multiply

module dsst_rem_split import dsst_pkg::*; (
  input  logic [TargetW-1:0]  rem_s_i,
  output logic [TimeFldW-1:0] min_o,
  output logic [TimeFldW-1:0] sec_o
);

  logic [2*TargetW-1:0] prod;
  logic [TimeFldW-1:0]  quo;
  logic [TargetW-1:0]   whole;
  logic [TargetW-1:0]   left;

  assign prod  = {{TargetW{1'b0}}, rem_s_i} * {{TargetW{1'b0}}, RECIP_60};
  assign quo   = prod[RECIP_SHIFT +: TimeFldW];
  // quo * 60 as 64q - 4q
  assign whole = ({{(TargetW-TimeFldW){1'b0}}, quo} << 6) -
                 ({{(TargetW-TimeFldW){1'b0}}, quo} << 2);
  assign left  = rem_s_i - whole;
  assign min_o = quo;
  assign sec_o = left[TimeFldW-1:0];

endmodule

@@ hdl/dive_safety_stop_tracker_unit.sv @@
`timescale 1ns / 1ps
// dive_safety_stop_tracker_unit: top level of the dive safety stop tracker
// depends on dsst_pkg, dsst_stop_fsm and dsst_rem_split

// usage
// - input channel in_valid_i / in_stall_o carries one depth sample per beat
// - output channel out_valid_o / out_stall_i carries one status beat per sample
// - config channel cfg_valid_i / cfg_ready_o writes one register per beat;
//   cfg_ready_o is always high; the user must write only while idle, which the
//   block itself does not enforce
// - three register stages: input register, stop machine stage, result register
// - one sample per cycle sustained unless the output stalls; the stop machine
//   state updates per sample, so back-to-back samples see each other's effect
// - a stall on the output holds the result register; the stages behind it keep
//   filling until every stage is occupied, then in_stall_o rises
// - reset empties the pipeline, loads the register defaults and returns the
//   stop machine to not started with zero max depth and timer

module dive_safety_stop_tracker_unit import dsst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;

  // pipeline occupancy
  logic in_valid_q, mid_valid_q, out_valid_q;
  logic in_ready, mid_ready, out_ready;
  logic in_take, mid_take, out_take;

  in_beat_t     in_q;
  stop_status_t status;
  stop_status_t mid_q;
  out_beat_t    out_q;
  logic [TimeFldW-1:0] rem_min, rem_sec;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_depth_cm  <= TRIGGER_RST;
      cfg_q.window_shallow_cm <= SHALLOW_RST;
      cfg_q.window_deep_cm    <= DEEP_RST;
      cfg_q.rearm_depth_cm    <= REARM_RST;
      cfg_q.stop_target_s     <= TARGET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TRIGGER_DEPTH:  cfg_q.trigger_depth_cm  <= cfg_data_i;
        CFG_WINDOW_SHALLOW: cfg_q.window_shallow_cm <= cfg_data_i;
        CFG_WINDOW_DEEP:    cfg_q.window_deep_cm    <= cfg_data_i;
        CFG_REARM_DEPTH:    cfg_q.rearm_depth_cm    <= cfg_data_i;
        CFG_STOP_TARGET:    cfg_q.stop_target_s     <= cfg_data_i[TargetW-1:0];
        default: begin
        end
      endcase
    end
  end

  // a stage may load when it is empty or its beat moves on this cycle
  assign out_ready = !out_valid_q || !out_stall_i;
  assign mid_ready = !mid_valid_q || out_ready;
  assign in_ready  = !in_valid_q || mid_ready;

  assign in_take  = in_valid_i && in_ready;
  assign mid_take = in_valid_q && mid_ready;
  assign out_take = mid_valid_q && out_ready;

  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (mid_ready) begin
        mid_valid_q <= in_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // stop machine: state advances as the sample leaves the input register
  dsst_stop_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (mid_take),
    .beat_i   (in_q),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  always_ff @(posedge clk_i) begin
    if (mid_take) begin
      mid_q <= status;
    end
  end

  // minutes and seconds of the countdown
  dsst_rem_split u_split (
    .rem_s_i (mid_q.rem_s),
    .min_o   (rem_min),
    .sec_o   (rem_sec)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_q.stop_phase    <= mid_q.phase;
      out_q.stop_shown    <= mid_q.shown;
      out_q.remaining_min <= rem_min;
      out_q.remaining_sec <= rem_sec;
      out_q.max_depth_out <= mid_q.max_depth;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
